### rtl/lha_pkg.sv
// Shared types and constants for the latency histogram accumulator.
// Used by lha_divider and latency_histogram_accumulator_core; no dependencies.
package lha_pkg;

  // Storage defaults
  localparam int unsigned MAX_BINS = 64;

  // Field widths fixed by the transaction format
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned WIDTH_W  = 32;
  localparam int unsigned BINS_W   = 7;
  localparam int unsigned SEL_W    = 6;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Register reset values
  localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST = WIDTH_W'(1000000);
  localparam logic [BINS_W-1:0]  BINS_RST      = BINS_W'(1);

  // Serial divider: one quotient bit per step
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_USED = 1'b1;

  // Result status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELAPSED,
    ST_TOTAL,
    ST_DIVIDE,
    ST_CLAMP,
    ST_READ,
    ST_UPDATE,
    ST_RESPOND
  } state_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [TIME_W-1:0] start_usec;
    logic [TIME_W-1:0] end_usec;
    logic [SEL_W-1:0]  bin_select;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic [SEL_W-1:0]   bin_index;
    logic [COUNT_W-1:0] bin_count;
    logic [TIME_W-1:0]  total_usec;
  } out_item_t;

endpackage

### rtl/lha_divider.sv
// Restoring serial divider: 63-bit dividend by 32-bit divisor, one bit a cycle.
// Depends on lha_pkg for widths and step count.
module lha_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lha_pkg::TIME_W-1:0]   dividend_i,
  input  logic [lha_pkg::WIDTH_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [lha_pkg::TIME_W-1:0]   quotient_o
);

  logic [lha_pkg::TIME_W-1:0]    quo_q, quo_d;
  logic [lha_pkg::WIDTH_W-1:0]   rem_q, rem_d;
  logic [lha_pkg::WIDTH_W-1:0]   dvs_q, dvs_d;
  logic [lha_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;

  logic [lha_pkg::WIDTH_W:0] shifted;
  logic [lha_pkg::WIDTH_W:0] diff;
  logic                      fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_q, quo_q[lha_pkg::TIME_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    fits    = (shifted >= {1'b0, dvs_q});
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[lha_pkg::TIME_W-2:0], fits};
      rem_d = fits ? diff[lha_pkg::WIDTH_W-1:0] : shifted[lha_pkg::WIDTH_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == lha_pkg::DIV_CNT_W'(lha_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

### rtl/latency_histogram_accumulator_core.sv
// Latency histogram accumulator: top level with sequencer, bin memory and totals.
// Depends on lha_pkg and lha_divider.
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_data_i) carries one command
//   transaction: add sample, read bin, clear all, or an ignored code.
// - Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//   result transaction per command, in order.
// - Configuration (cfg_we_i / cfg_index_i / cfg_data_i) sets the bin width and
//   the number of bins in use; write it only while no command is in flight.
// - One command is processed at a time; in_stall_o stays high until its result
//   reaches the output register, so a new sample waits for the previous one.
// - States after acceptance, each path ending in RESPOND: add ELAPSED, TOTAL,
//   serial divider (63 steps, one quotient bit per cycle), CLAMP, READ, UPDATE;
//   rejected add ELAPSED; read READ (one registered memory read), UPDATE; clear
//   zeroes one entry per cycle; ignored code or out-of-store read: none.
// - After reset the block sweeps the bin memory, zeroing every entry, before it
//   takes its first command; configuration writes are taken during the sweep.
// - The result sits in an output register; a stalled result holds there and the
//   next command may be accepted, but its result waits until the slot frees.
module latency_histogram_accumulator_core #(
  parameter int unsigned MaxBins = lha_pkg::MAX_BINS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  lha_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output lha_pkg::out_item_t             out_data_o,
  input  logic                           cfg_we_i,
  input  logic [lha_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lha_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned AddrW = (MaxBins > 1) ? $clog2(MaxBins) : 1;

  lha_pkg::state_e state_q, state_d;

  // Configuration registers
  logic [lha_pkg::WIDTH_W-1:0] bin_width_q;
  logic [lha_pkg::BINS_W-1:0]  bins_used_q;

  // Command and working registers
  lha_pkg::cmd_e               cmd_q, cmd_d;
  logic [lha_pkg::TIME_W-1:0]  start_q, start_d;
  logic [lha_pkg::TIME_W-1:0]  end_q, end_d;
  logic [lha_pkg::TIME_W-1:0]  elapsed_q, elapsed_d;
  logic [lha_pkg::TIME_W-1:0]  total_q, total_d;
  logic [AddrW-1:0]            addr_q, addr_d;
  logic [AddrW-1:0]            clr_cnt_q, clr_cnt_d;
  logic                        clr_reply_q, clr_reply_d;
  lha_pkg::out_item_t          res_q, res_d;
  lha_pkg::out_item_t          out_q, out_d;
  logic                        out_valid_q, out_valid_d;

  // Bin memory
  logic [lha_pkg::COUNT_W-1:0] mem [MaxBins];
  logic [lha_pkg::COUNT_W-1:0] rd_q;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [lha_pkg::COUNT_W-1:0] mem_wdata;

  // Divider hookup
  logic                        div_start;
  logic                        div_done;
  logic [lha_pkg::TIME_W-1:0]  div_quo;

  // Misc combinational values
  logic                        in_accept;
  logic                        out_free;
  logic [lha_pkg::TIME_W:0]    diff;
  logic [lha_pkg::TIME_W:0]    sum;
  logic [31:0]                 eff_bins;
  logic [AddrW-1:0]            last_bin;
  logic [31:0]                 sel_ext;
  logic                        sel_in_range;
  logic [lha_pkg::COUNT_W-1:0] bumped;

  assign in_accept = in_valid_i && (state_q == lha_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  lha_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed_q),
    .divisor_i  (bin_width_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= lha_pkg::BIN_WIDTH_RST;
      bins_used_q <= lha_pkg::BINS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lha_pkg::CFG_BIN_WIDTH: bin_width_q <= cfg_data_i[lha_pkg::WIDTH_W-1:0];
        lha_pkg::CFG_BINS_USED: bins_used_q <= cfg_data_i[lha_pkg::BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective last bin: zero bins count as one, clamp to the memory depth
  always_comb begin
    if (bins_used_q == '0) begin
      eff_bins = 32'd1;
    end else if (32'(bins_used_q) > 32'(MaxBins)) begin
      eff_bins = 32'(MaxBins);
    end else begin
      eff_bins = 32'(bins_used_q);
    end
    last_bin = AddrW'(eff_bins - 32'd1);
  end

  assign sel_ext      = 32'(in_data_i.bin_select);
  assign sel_in_range = (sel_ext < 32'(MaxBins));
  assign diff         = {1'b0, end_q} - {1'b0, start_q};
  assign sum          = {1'b0, total_q} + {1'b0, elapsed_q};
  assign bumped       = (rd_q == '1) ? rd_q : rd_q + 1'b1;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lha_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AddrW'(MaxBins - 1)) begin
          state_d = clr_reply_q ? lha_pkg::ST_RESPOND : lha_pkg::ST_IDLE;
        end
      end
      lha_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (lha_pkg::cmd_e'(in_data_i.command))
            lha_pkg::CMD_ADD:   state_d = lha_pkg::ST_ELAPSED;
            lha_pkg::CMD_READ:  state_d = sel_in_range ? lha_pkg::ST_READ
                                                       : lha_pkg::ST_RESPOND;
            lha_pkg::CMD_CLEAR: state_d = lha_pkg::ST_CLEAR;
            default:            state_d = lha_pkg::ST_RESPOND;
          endcase
        end
      end
      lha_pkg::ST_ELAPSED: begin
        state_d = diff[lha_pkg::TIME_W] ? lha_pkg::ST_RESPOND : lha_pkg::ST_TOTAL;
      end
      lha_pkg::ST_TOTAL:   state_d = lha_pkg::ST_DIVIDE;
      lha_pkg::ST_DIVIDE: begin
        if (div_done) begin
          state_d = lha_pkg::ST_CLAMP;
        end
      end
      lha_pkg::ST_CLAMP:   state_d = lha_pkg::ST_READ;
      lha_pkg::ST_READ:    state_d = lha_pkg::ST_UPDATE;
      lha_pkg::ST_UPDATE:  state_d = lha_pkg::ST_RESPOND;
      lha_pkg::ST_RESPOND: begin
        if (out_free) begin
          state_d = lha_pkg::ST_IDLE;
        end
      end
      default:             state_d = lha_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cmd_d       = cmd_q;
    start_d     = start_q;
    end_d       = end_q;
    elapsed_d   = elapsed_q;
    total_d     = total_q;
    addr_d      = addr_q;
    clr_cnt_d   = clr_cnt_q;
    clr_reply_d = clr_reply_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = bumped;
    div_start   = 1'b0;
    case (state_q)
      lha_pkg::ST_CLEAR: begin
        // Zero one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
      lha_pkg::ST_IDLE: begin
        if (in_accept) begin
          cmd_d             = lha_pkg::cmd_e'(in_data_i.command);
          start_d           = in_data_i.start_usec;
          end_d             = in_data_i.end_usec;
          addr_d            = AddrW'(sel_ext);
          res_d.status      = lha_pkg::STATUS_OK;
          res_d.bin_index   = '0;
          res_d.bin_count   = '0;
          res_d.total_usec  = total_q;
          case (lha_pkg::cmd_e'(in_data_i.command))
            lha_pkg::CMD_READ: begin
              res_d.bin_index = in_data_i.bin_select;
            end
            lha_pkg::CMD_CLEAR: begin
              total_d          = '0;
              res_d.total_usec = '0;
              clr_cnt_d        = '0;
              clr_reply_d      = 1'b1;
            end
            default: ;
          endcase
        end
      end
      lha_pkg::ST_ELAPSED: begin
        // Reject when end precedes start
        elapsed_d = diff[lha_pkg::TIME_W-1:0];
        if (diff[lha_pkg::TIME_W]) begin
          res_d.status = lha_pkg::STATUS_REJECT;
        end
      end
      lha_pkg::ST_TOTAL: begin
        // Saturating running total, then launch the division
        total_d   = sum[lha_pkg::TIME_W] ? '1 : sum[lha_pkg::TIME_W-1:0];
        div_start = 1'b1;
      end
      lha_pkg::ST_CLAMP: begin
        addr_d = (div_quo > lha_pkg::TIME_W'(last_bin)) ? last_bin : AddrW'(div_quo);
      end
      lha_pkg::ST_UPDATE: begin
        if (cmd_q == lha_pkg::CMD_ADD) begin
          mem_we           = 1'b1;
          res_d.bin_index  = lha_pkg::SEL_W'(addr_q);
          res_d.bin_count  = bumped;
          res_d.total_usec = total_q;
        end else begin
          res_d.bin_count  = rd_q;
        end
      end
      lha_pkg::ST_RESPOND: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lha_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_reply_q <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
      cmd_q       <= lha_pkg::CMD_NONE;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_reply_q <= (state_q == lha_pkg::ST_CLEAR && state_d != lha_pkg::ST_CLEAR)
                     ? 1'b0 : clr_reply_d;
      out_valid_q <= out_valid_d;
      total_q     <= total_d;
      cmd_q       <= cmd_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    end_q     <= end_d;
    elapsed_q <= elapsed_d;
    addr_q    <= addr_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // Bin memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  assign in_stall_o  = (state_q != lha_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/latency_histogram_accumulator_core_test.sv
// Self-checking testbench for latency_histogram_accumulator_core: directed and random commands.
// Depends on lha_pkg and the core RTL; results are predicted in-bench and checked in order.
`timescale 1ns / 1ps

module latency_histogram_accumulator_core_test;

  localparam logic [63:0] TIME_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          PHASE_ITEMS = 205;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  lha_pkg::in_item_t             in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  lha_pkg::out_item_t            out_data_o;
  logic                          cfg_we_i;
  logic [lha_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [lha_pkg::CFG_W-1:0]     cfg_data_i;

  // Predicted histogram store and register copies
  logic [lha_pkg::COUNT_W-1:0] hist_bins [lha_pkg::MAX_BINS];
  logic [lha_pkg::TIME_W-1:0]  hist_total;
  logic [lha_pkg::WIDTH_W-1:0] cfg_bin_width;
  logic [lha_pkg::BINS_W-1:0]  cfg_bins_used;

  lha_pkg::out_item_t pending_results [$];
  int                 mismatches;
  int                 burst_left;
  int                 hold_request;
  int                 quiet_cycles;

  latency_histogram_accumulator_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int unsigned used_bins();
    int unsigned n;
    n = 32'(cfg_bins_used);
    if (n == 0) n = 1;
    if (n > lha_pkg::MAX_BINS) n = lha_pkg::MAX_BINS;
    return n;
  endfunction

  function automatic void clear_histogram();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    hist_total = '0;
  endfunction

  // Append a prediction behind the older ones
  function automatic void store_result(input lha_pkg::out_item_t res);
    pending_results = {pending_results, res};
  endfunction

  // Work out the result of one command and advance the predicted store
  function automatic lha_pkg::out_item_t apply_command(input lha_pkg::in_item_t it);
    lha_pkg::out_item_t res;
    logic [63:0]        elapsed;
    logic [63:0]        sum;
    logic [63:0]        quot;
    logic [63:0]        last;
    res.status    = lha_pkg::STATUS_OK;
    res.bin_index = '0;
    res.bin_count = '0;
    case (it.command)
      lha_pkg::CMD_ADD: begin
        if (it.end_usec < it.start_usec) begin
          res.status = lha_pkg::STATUS_REJECT;
        end else begin
          elapsed = {1'b0, it.end_usec - it.start_usec};
          sum = {1'b0, hist_total} + elapsed;
          if (sum > TIME_MAX) sum = TIME_MAX;
          hist_total = sum[lha_pkg::TIME_W-1:0];
          if (cfg_bin_width == '0) quot = '1;
          else quot = elapsed / {32'b0, cfg_bin_width};
          last = 64'(used_bins() - 1);
          if (quot > last) quot = last;
          if (hist_bins[quot[lha_pkg::SEL_W-1:0]] != '1)
            hist_bins[quot[lha_pkg::SEL_W-1:0]] = hist_bins[quot[lha_pkg::SEL_W-1:0]] + 1'b1;
          res.bin_index = quot[lha_pkg::SEL_W-1:0];
          res.bin_count = hist_bins[quot[lha_pkg::SEL_W-1:0]];
        end
      end
      lha_pkg::CMD_READ: begin
        res.bin_index = it.bin_select;
        res.bin_count = hist_bins[it.bin_select];
      end
      lha_pkg::CMD_CLEAR: clear_histogram();
      default: ;
    endcase
    res.total_usec = hist_total;
    return res;
  endfunction

  // Fully random fields; callers override what matters
  function automatic lha_pkg::in_item_t random_fields();
    lha_pkg::in_item_t it;
    logic [63:0]       r;
    it.command    = 2'($urandom_range(0, 3));
    r             = rand64();
    it.start_usec = r[lha_pkg::TIME_W-1:0];
    r             = rand64();
    it.end_usec   = r[lha_pkg::TIME_W-1:0];
    it.bin_select = lha_pkg::SEL_W'($urandom_range(0, 63));
    return it;
  endfunction

  function automatic lha_pkg::in_item_t cmd_item(input lha_pkg::cmd_e cmd,
                                                 input int unsigned sel);
    lha_pkg::in_item_t it;
    it            = random_fields();
    it.command    = cmd;
    it.bin_select = lha_pkg::SEL_W'(sel);
    return it;
  endfunction

  // Add command with a given elapsed time at a random position on the time axis
  function automatic lha_pkg::in_item_t sample_with(input logic [63:0] elapsed);
    lha_pkg::in_item_t it;
    logic [63:0]       s;
    logic [63:0]       e;
    it         = cmd_item(lha_pkg::CMD_ADD, $urandom_range(0, 63));
    e          = (elapsed > TIME_MAX) ? TIME_MAX : elapsed;
    s          = rand64() % (TIME_MAX - e + 1);
    it.start_usec = s[lha_pkg::TIME_W-1:0];
    e          = s + e;
    it.end_usec   = e[lha_pkg::TIME_W-1:0];
    return it;
  endfunction

  function automatic lha_pkg::in_item_t rejected_sample();
    lha_pkg::in_item_t it;
    logic [63:0]       s;
    logic [63:0]       e;
    it = cmd_item(lha_pkg::CMD_ADD, $urandom_range(0, 63));
    s  = rand64() & TIME_MAX;
    if (s == 0) s = 64'd1;
    e  = rand64() % s;
    it.start_usec = s[lha_pkg::TIME_W-1:0];
    it.end_usec   = e[lha_pkg::TIME_W-1:0];
    return it;
  endfunction

  // Elapsed times spread over the bins, their edges and beyond
  function automatic logic [63:0] pick_elapsed();
    logic [63:0] w;
    logic [63:0] k;
    logic [63:0] e;
    w = {32'b0, cfg_bin_width};
    k = 64'($urandom_range(0, used_bins() + 1));
    case ($urandom_range(0, 5))
      0, 1: begin
        e = k * w;
        if (w != 0) e = e + rand64() % w;
      end
      2: begin
        e = k * w;
        if (e != 0 && $urandom_range(0, 1) == 0) e = e - 1;
      end
      3: e = 64'($urandom_range(0, 2000));
      4: e = rand64() & TIME_MAX;
      default: e = (rand64() & TIME_MAX) >> $urandom_range(0, 62);
    endcase
    return e;
  endfunction

  function automatic lha_pkg::in_item_t random_command();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return sample_with(pick_elapsed());
    if (r < 62) return rejected_sample();
    if (r < 67) return cmd_item(lha_pkg::CMD_ADD, $urandom_range(0, 63));
    if (r < 88) begin
      if ($urandom_range(0, 1) == 0)
        return cmd_item(lha_pkg::CMD_READ, $urandom_range(0, used_bins() - 1));
      return cmd_item(lha_pkg::CMD_READ, $urandom_range(0, 63));
    end
    if (r < 91) return cmd_item(lha_pkg::CMD_CLEAR, $urandom_range(0, 63));
    return cmd_item(lha_pkg::CMD_NONE, $urandom_range(0, 63));
  endfunction

  // Offer one transaction, hold it until taken, then predict its result
  task automatic send_item(input lha_pkg::in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    store_result(apply_command(it));
  endtask

  // Send in bursts with random gaps; noise on the bus while idle
  task automatic issue(input lha_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1:       gap = $urandom_range(1, 90);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        in_data_i  <= random_fields();
        repeat (gap - 1) begin
          @(negedge clk_i);
          in_data_i <= random_fields();
        end
      end
    end
    burst_left--;
    send_item(it);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    in_data_i  <= random_fields();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lha_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lha_pkg::CFG_W-1:0]     data);
    drain();
    if (idx == lha_pkg::CFG_BINS_USED)
      data[lha_pkg::CFG_W-1:lha_pkg::BINS_W] = (lha_pkg::CFG_W - lha_pkg::BINS_W)'($urandom());
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= $urandom();
    if (idx == lha_pkg::CFG_BIN_WIDTH) cfg_bin_width = data[lha_pkg::WIDTH_W-1:0];
    else cfg_bins_used = data[lha_pkg::BINS_W-1:0];
  endtask

  task automatic test_reset_defaults();
    issue(sample_with(64'd0));
    issue(sample_with(64'd5_000_000));
    issue(cmd_item(lha_pkg::CMD_READ, 0));
  endtask

  task automatic test_bin_boundaries();
    lha_pkg::in_item_t it;
    write_reg(lha_pkg::CFG_BIN_WIDTH, 32'd1000);
    write_reg(lha_pkg::CFG_BINS_USED, 32'd8);
    issue(sample_with(64'd999));
    issue(sample_with(64'd1000));
    issue(sample_with(64'd7999));
    issue(sample_with(64'd8000));
    // End before start at the extremes of the time fields
    it = cmd_item(lha_pkg::CMD_ADD, 63);
    it.start_usec = '1;
    it.end_usec   = '0;
    issue(it);
    issue(cmd_item(lha_pkg::CMD_READ, 7));
    issue(cmd_item(lha_pkg::CMD_READ, 63));
    issue(cmd_item(lha_pkg::CMD_NONE, 0));
  endtask

  task automatic test_config_extremes();
    // Zero width sends everything to the last bin
    write_reg(lha_pkg::CFG_BIN_WIDTH, 32'd0);
    write_reg(lha_pkg::CFG_BINS_USED, 32'd64);
    issue(sample_with(64'd1));
    // Zero bins in use behaves as one bin
    write_reg(lha_pkg::CFG_BINS_USED, 32'd0);
    issue(sample_with(64'd123));
    // Bins above the store size are capped
    write_reg(lha_pkg::CFG_BIN_WIDTH, 32'd1);
    write_reg(lha_pkg::CFG_BINS_USED, 32'd127);
    issue(sample_with(64'd63));
    issue(sample_with(64'd64));
    write_reg(lha_pkg::CFG_BIN_WIDTH, 32'hFFFF_FFFF);
    issue(sample_with(64'h2_0000_0000));
    // Lowering the bin count keeps the upper entries readable
    write_reg(lha_pkg::CFG_BINS_USED, 32'd4);
    issue(cmd_item(lha_pkg::CMD_READ, 63));
  endtask

  task automatic test_saturation_and_clear();
    lha_pkg::in_item_t it;
    it = cmd_item(lha_pkg::CMD_ADD, 0);
    it.start_usec = '0;
    it.end_usec   = '1;
    issue(it);
    issue(it);
    issue(cmd_item(lha_pkg::CMD_READ, $urandom_range(0, 63)));
    issue(cmd_item(lha_pkg::CMD_CLEAR, 63));
    issue(cmd_item(lha_pkg::CMD_READ, 63));
  endtask

  task automatic test_random_traffic();
    logic [lha_pkg::WIDTH_W-1:0] widths [8];
    logic [lha_pkg::CFG_W-1:0]   bins_list [8];
    widths    = '{32'd1, 32'hFFFF_FFFF, 32'd1000, 32'd7, 32'd0, 32'd1_000_000, 32'd0, 32'd3};
    bins_list = '{32'd64, 32'd64, 32'd16, 32'd100, 32'd5, 32'd1, 32'd0, 32'd0};
    widths[6]    = $urandom_range(1, 5000);
    bins_list[6] = $urandom_range(1, 127);
    for (int p = 0; p < 8; p++) begin
      write_reg(lha_pkg::CFG_BIN_WIDTH, widths[p]);
      write_reg(lha_pkg::CFG_BINS_USED, bins_list[p]);
      repeat (PHASE_ITEMS) issue(random_command());
    end
  endtask

  // Hold the output off for a long stretch while commands keep coming
  task automatic test_output_backpressure();
    write_reg(lha_pkg::CFG_BIN_WIDTH, 32'd10);
    write_reg(lha_pkg::CFG_BINS_USED, 32'd32);
    hold_request = 400;
    repeat (30) send_item(random_command());
  endtask

  // Receiver: stall pattern of its own, plus a long hold-off on request
  initial begin
    int mode;
    int left;
    int hold;
    out_stall_i = 1'b0;
    left = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold = hold_request;
        hold_request = 0;
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(10, 200);
        end
        left--;
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= ($urandom_range(0, 3) != 0);
          default: out_stall_i <= ((left % 5) < 2);
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    lha_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (want.status !== out_data_o.status) begin
          $display("%0t: status expected %0h got %0h", $time, want.status, out_data_o.status);
          mismatches++;
        end
        if (want.bin_index !== out_data_o.bin_index) begin
          $display("%0t: bin_index expected %0d got %0d", $time, want.bin_index,
                   out_data_o.bin_index);
          mismatches++;
        end
        if (want.bin_count !== out_data_o.bin_count) begin
          $display("%0t: bin_count expected %0d got %0d", $time, want.bin_count,
                   out_data_o.bin_count);
          mismatches++;
        end
        if (want.total_usec !== out_data_o.total_usec) begin
          $display("%0t: total_usec expected %0h got %0h", $time, want.total_usec,
                   out_data_o.total_usec);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    burst_left    = 0;
    hold_request  = 0;
    quiet_cycles  = 0;
    cfg_bin_width = lha_pkg::BIN_WIDTH_RST;
    cfg_bins_used = lha_pkg::BINS_RST;
    clear_histogram();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_bin_boundaries();
    test_config_extremes();
    test_saturation_and_clear();
    test_random_traffic();
    test_output_backpressure();

    drain();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
